[design/aeskx_pkg.sv]
// shared types, constants and byte functions for the aes-128 key expansion
package aeskx_pkg;

	localparam int unsigned KEY_HALF_W  = 64;
	localparam int unsigned WORD_W      = 32;
	localparam int unsigned SCHED_WORDS = 44;
	localparam int unsigned INDEX_W     = $clog2(SCHED_WORDS);
	localparam int unsigned ROUNDS      = 10;

	localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(SCHED_WORDS - 1);

	// controller to datapath commands
	typedef struct packed {
		logic               load;
		logic               step;
		logic [INDEX_W-1:0] index;
	} aeskx_cmd_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] RCON [ROUNDS] = '{
		8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
	};

	// round constant for a group of four words; groups past the last round read zero
	function automatic logic [7:0] rcon_of(input logic [INDEX_W-3:0] group);
		logic [7:0] r;
		r = 8'h00;
		if (32'(group) < ROUNDS) begin
			r = RCON[4'(group)];
		end
		return r;
	endfunction

	// rotate left by one byte, then substitute each byte
	function automatic logic [WORD_W-1:0] rot_sub(input logic [WORD_W-1:0] w);
		logic [WORD_W-1:0] r;
		r = {w[23:0], w[31:24]};
		return {SBOX[r[31:24]], SBOX[r[23:16]], SBOX[r[15:8]], SBOX[r[7:0]]};
	endfunction

endpackage

[design/aeskx_if.sv]
// handshake channels for key input and round-key word output
interface aeskx_key_if;
	logic        valid;
	logic        ready;
	logic [63:0] key_high;
	logic [63:0] key_low;

	modport source (output valid, output key_high, output key_low, input ready);
	modport sink (input valid, input key_high, input key_low, output ready);
endinterface

interface aeskx_word_if;
	logic        valid;
	logic        ready;
	logic [31:0] round_key_word;
	logic [5:0]  word_index;
	logic        last_word;

	modport source (output valid, output round_key_word, output word_index, output last_word,
		input ready);
	modport sink (input valid, input round_key_word, input word_index, input last_word,
		output ready);
endinterface

[design/aeskx_ctrl.sv]
// sequencer: key acceptance, word counter and output valid
module aeskx_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	output aeskx_pkg::aeskx_cmd_t cmd
);
	import aeskx_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t             state_q;
	logic [INDEX_W-1:0] index_q;
	logic               out_valid_q;
	logic               load;
	logic               step;

	// a new word may enter the output register when it is empty or being drained
	assign load     = (state_q == ST_IDLE) && in_valid;
	assign step     = (state_q == ST_RUN) && (!out_valid_q || out_ready);
	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	assign cmd.load  = load;
	assign cmd.step  = step;
	assign cmd.index = index_q;

	// state and word counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			index_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (load) begin
						state_q <= ST_RUN;
						index_q <= '0;
					end
				end
				ST_RUN: begin
					if (step) begin
						if (index_q == LAST_INDEX) begin
							state_q <= ST_IDLE;
						end
						index_q <= index_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output valid, held until the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end
endmodule

[design/aeskx_datapath.sv]
// four-word sliding window and output word register
module aeskx_datapath (
	input  logic                               clk,
	input  aeskx_pkg::aeskx_cmd_t              cmd,
	input  logic [aeskx_pkg::KEY_HALF_W-1:0]   key_high,
	input  logic [aeskx_pkg::KEY_HALF_W-1:0]   key_low,
	output logic [aeskx_pkg::WORD_W-1:0]       round_key_word,
	output logic [aeskx_pkg::INDEX_W-1:0]      word_index,
	output logic                               last_word
);
	import aeskx_pkg::*;

	logic [WORD_W-1:0]  win_q [4];
	logic [WORD_W-1:0]  word_q;
	logic [INDEX_W-1:0] index_q;
	logic               last_q;
	logic [WORD_W-1:0]  mix;
	logic [WORD_W-1:0]  next_word;

	// word i+4 from window holding words i..i+3
	always_comb begin
		mix = win_q[3];
		if (cmd.index[1:0] == 2'b00) begin
			mix = rot_sub(win_q[3]) ^ {rcon_of(cmd.index[INDEX_W-1:2]), 24'h000000};
		end
		next_word = win_q[0] ^ mix;
	end

	// window load and shift
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			win_q[0] <= key_high[63:32];
			win_q[1] <= key_high[31:0];
			win_q[2] <= key_low[63:32];
			win_q[3] <= key_low[31:0];
		end else if (cmd.step) begin
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
			win_q[2] <= win_q[3];
			win_q[3] <= next_word;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			word_q  <= win_q[0];
			index_q <= cmd.index;
			last_q  <= (cmd.index == LAST_INDEX);
		end
	end

	assign round_key_word = word_q;
	assign word_index     = index_q;
	assign last_word      = last_q;
endmodule

[design/aes128_key_expansion_top.sv]
// aes-128 key expansion: one key in, 44 round-key words out, one word per cycle
// while word.ready is high; the first word is valid once the key transfer has moved
// the sequencer to run and its first step has loaded the output register; the word
// counter and four-word window produce each word; no new key is taken before the last
// word steps out; reset: arst_n clears the sequencer and output valid; payload registers are not reset
module aes128_key_expansion_top (
	input  logic          clk,
	input  logic          arst_n,
	aeskx_key_if.sink     key,
	aeskx_word_if.source  word
);
	import aeskx_pkg::*;

	aeskx_cmd_t cmd;

	// sequencer
	aeskx_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (key.valid),
		.in_ready  (key.ready),
		.out_valid (word.valid),
		.out_ready (word.ready),
		.cmd       (cmd)
	);

	// word generation
	aeskx_datapath u_datapath (
		.clk            (clk),
		.cmd            (cmd),
		.key_high       (key.key_high),
		.key_low        (key.key_low),
		.round_key_word (word.round_key_word),
		.word_index     (word.word_index),
		.last_word      (word.last_word)
	);
endmodule
